>>> rtl/mmrope_pkg.sv
// ----------------------------------------------------------------------------
// mmrope_pkg
// Word types and codes for the multimodal rotary position generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mmrope_pkg;

	localparam int GRID_FIELD_W = 11;
	localparam int POS_W        = 31;
	localparam int DELTA_W      = 32;
	localparam int TOKEN_W      = 32;

	localparam logic [1:0] MODE_TEXT  = 2'd0;
	localparam logic [1:0] MODE_IMAGE = 2'd1;
	localparam logic [1:0] MODE_END   = 2'd2;
	localparam logic [1:0] MODE_GEN   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_GRID     = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic                    run_first;
		logic [GRID_FIELD_W-1:0] grid_rows;
		logic [GRID_FIELD_W-1:0] grid_cols;
	} tok_t;

	typedef struct packed {
		logic [POS_W-1:0]          pos_time;
		logic [POS_W-1:0]          pos_row;
		logic [POS_W-1:0]          pos_col;
		logic signed [DELTA_W-1:0] delta_out;
		logic [1:0]                status;
	} pos_t;

endpackage

`default_nettype wire

>>> rtl/multimodal_rope_position_generator_top.sv
// ----------------------------------------------------------------------------
// multimodal_rope_position_generator_top
// Three-axis rotary position ids for a mixed text/image token stream.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  tok     | in  | tok_valid/tok_ready  | mmrope_pkg::tok_t (mode, grid)
//  pos     | out | pos_valid/pos_ready  | mmrope_pkg::pos_t (t/h/w, delta)
//
//  One word per cycle while pos_ready is high, via input register and result
//  register. The running state updates as the word leaves the input register.
//  tok_ready drops only while both registers are full and pos_ready is low.
//  Reset clears all state: base 0, no position seen, offset 0, no image run.
// ----------------------------------------------------------------------------
`default_nettype none

module multimodal_rope_position_generator_top #(
	parameter int MERGE_SIZE = 2,
	parameter int GRID_MAX   = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tok_valid,
	output logic                  tok_ready,
	input  wire mmrope_pkg::tok_t tok,
	output logic                  pos_valid,
	input  wire logic             pos_ready,
	output mmrope_pkg::pos_t      pos
);
	import mmrope_pkg::*;

	localparam int MW_RAW = $clog2(GRID_MAX / MERGE_SIZE + 1);
	localparam int MW     = (MW_RAW < 1) ? 1 : MW_RAW;
	// divide by merge size as multiply by a scaled reciprocal
	localparam int RSH    = 18;
	localparam int RW     = RSH + 1;
	localparam int RECIP  = (2 ** RSH + MERGE_SIZE - 1) / MERGE_SIZE;
	localparam int PW     = GRID_FIELD_W + RW;
	localparam int QW     = PW - RSH;

	localparam logic [TOKEN_W:0] BASE_LIMIT = 33'h0_8000_0000;

	// input stage
	tok_t tok_s1;
	logic v_s1;
	logic adv;

	// running state
	logic [31:0]            base_q;
	logic [31:0]            maxp1_q;   // largest position + 1, 0 when none
	logic [TOKEN_W-1:0]     tokens_q;
	logic signed [31:0]     rope_q;
	logic                   in_image_q;
	logic [MW-1:0]          row_q, col_q, mr_q, mc_q;

	// next state
	logic [31:0]            base_d, maxp1_d;
	logic [TOKEN_W-1:0]     tokens_d;
	logic signed [31:0]     rope_d;
	logic                   in_image_d;
	logic [MW-1:0]          row_d, col_d, mr_d, mc_d;
	pos_t                   res;

	// result register
	pos_t pos_q;
	logic pos_valid_q;

	// grid decode
	logic [PW-1:0]  prod_r, prod_c;
	logic [QW-1:0]  q_r, q_c;
	logic [QW+2:0]  back_r, back_c;
	logic           ok_r, ok_c;
	logic [MW-1:0]  mr_new, mc_new;

	// datapath temporaries
	logic [MW-1:0]        mr_e, mc_e, row_e, col_e, side_e;
	logic [MW:0]          col_inc, row_inc;
	logic [TOKEN_W:0]     img_end;
	logic                 tok_full;
	logic signed [33:0]   d34, p34;
	logic [31:0]          cand;

	assign adv       = v_s1 && (!pos_valid_q || pos_ready);
	assign tok_ready = !v_s1 || adv;
	assign pos_valid = pos_valid_q;
	assign pos       = pos_q;

	assign prod_r = PW'(tok_s1.grid_rows) * PW'(RECIP);
	assign prod_c = PW'(tok_s1.grid_cols) * PW'(RECIP);
	assign q_r    = prod_r[PW-1:RSH];
	assign q_c    = prod_c[PW-1:RSH];
	assign back_r = (QW+3)'(q_r) * (QW+3)'(MERGE_SIZE);
	assign back_c = (QW+3)'(q_c) * (QW+3)'(MERGE_SIZE);
	assign ok_r   = (tok_s1.grid_rows != '0)
		&& (32'(tok_s1.grid_rows) <= 32'(GRID_MAX))
		&& (back_r == (QW+3)'(tok_s1.grid_rows));
	assign ok_c   = (tok_s1.grid_cols != '0)
		&& (32'(tok_s1.grid_cols) <= 32'(GRID_MAX))
		&& (back_c == (QW+3)'(tok_s1.grid_cols));
	assign mr_new = q_r[MW-1:0];
	assign mc_new = q_c[MW-1:0];
	assign tok_full = &tokens_q;

	always_comb begin
		base_d     = base_q;
		maxp1_d    = maxp1_q;
		tokens_d   = tokens_q;
		rope_d     = rope_q;
		in_image_d = in_image_q;
		row_d      = row_q;
		col_d      = col_q;
		mr_d       = mr_q;
		mc_d       = mc_q;
		res        = '0;
		mr_e       = tok_s1.run_first ? mr_new : mr_q;
		mc_e       = tok_s1.run_first ? mc_new : mc_q;
		row_e      = tok_s1.run_first ? '0 : row_q;
		col_e      = tok_s1.run_first ? '0 : col_q;
		side_e     = (mr_e > mc_e) ? mr_e : mc_e;
		col_inc    = {1'b0, col_e} + (MW+1)'(1);
		row_inc    = {1'b0, row_e} + (MW+1)'(1);
		img_end    = {1'b0, base_q} + (TOKEN_W+1)'(side_e);
		d34        = (tokens_q == '0) ? 34'sd0
			: $signed({2'b00, maxp1_q}) - $signed({2'b00, tokens_q});
		p34        = $signed({2'b00, tokens_q}) + 34'(rope_q);
		cand       = '0;

		case (tok_s1.mode)
			MODE_TEXT: begin
				if (in_image_q) begin
					res.status = ST_MISMATCH;
				end else if (base_q[31] || tok_full) begin
					res.status = ST_OVERFLOW;
				end else begin
					cand         = base_q + 32'd1;
					maxp1_d      = (cand > maxp1_q) ? cand : maxp1_q;
					base_d       = cand;
					tokens_d     = tokens_q + 32'd1;
					res.pos_time = base_q[POS_W-1:0];
					res.pos_row  = base_q[POS_W-1:0];
					res.pos_col  = base_q[POS_W-1:0];
				end
			end
			MODE_IMAGE: begin
				if (tok_s1.run_first && in_image_q) begin
					res.status = ST_MISMATCH;
				end else if (tok_s1.run_first && !(ok_r && ok_c)) begin
					res.status = ST_GRID;
				end else if (tok_s1.run_first && img_end > BASE_LIMIT) begin
					res.status = ST_OVERFLOW;
				end else if (!tok_s1.run_first && !in_image_q) begin
					res.status = ST_MISMATCH;
				end else if (tok_full) begin
					res.status = ST_OVERFLOW;
				end else begin
					tokens_d     = tokens_q + 32'd1;
					mr_d         = mr_e;
					mc_d         = mc_e;
					in_image_d   = 1'b1;
					res.pos_time = base_q[POS_W-1:0];
					res.pos_row  = POS_W'(base_q + 32'(row_e));
					res.pos_col  = POS_W'(base_q + 32'(col_e));
					if (col_inc >= {1'b0, mc_e}) begin
						col_d = '0;
						if (row_inc >= {1'b0, mr_e}) begin
							// run done: base steps by the larger merged side
							cand       = img_end[31:0];
							maxp1_d    = (cand > maxp1_q) ? cand : maxp1_q;
							base_d     = cand;
							row_d      = '0;
							in_image_d = 1'b0;
						end else begin
							row_d = row_inc[MW-1:0];
						end
					end else begin
						row_d = row_e;
						col_d = col_inc[MW-1:0];
					end
				end
			end
			MODE_END: begin
				if (in_image_q) begin
					res.status = ST_MISMATCH;
				end else if (d34[33:31] != 3'b000 && d34[33:31] != 3'b111) begin
					res.status = ST_OVERFLOW;
				end else begin
					rope_d        = d34[31:0];
					res.delta_out = d34[31:0];
				end
			end
			MODE_GEN: begin
				if (in_image_q) begin
					res.status = ST_MISMATCH;
				end else if (tok_full || p34[33:31] != 3'b000) begin
					res.status = ST_OVERFLOW;
				end else begin
					tokens_d     = tokens_q + 32'd1;
					res.pos_time = p34[POS_W-1:0];
					res.pos_row  = p34[POS_W-1:0];
					res.pos_col  = p34[POS_W-1:0];
				end
			end
			default: begin
				res.status = ST_MISMATCH;
			end
		endcase

		// any error drops an open run and nothing else
		if (res.status != ST_OK) begin
			in_image_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (tok_valid && tok_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_valid && tok_ready) begin
			tok_s1 <= tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			maxp1_q    <= '0;
			tokens_q   <= '0;
			rope_q     <= '0;
			in_image_q <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			mr_q       <= '0;
			mc_q       <= '0;
		end else if (adv) begin
			base_q     <= base_d;
			maxp1_q    <= maxp1_d;
			tokens_q   <= tokens_d;
			rope_q     <= rope_d;
			in_image_q <= in_image_d;
			row_q      <= row_d;
			col_q      <= col_d;
			mr_q       <= mr_d;
			mc_q       <= mc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_valid_q <= 1'b0;
		end else if (adv) begin
			pos_valid_q <= 1'b1;
		end else if (pos_ready) begin
			pos_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid_q && pos_q.status != ST_OK) |-> (pos_q.pos_time == '0
			&& pos_q.pos_row == '0 && pos_q.pos_col == '0 && pos_q.delta_out == '0))
		else $error("error word carries a position or offset");

	a_run_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		in_image_q |-> (row_q < mr_q && col_q < mc_q))
		else $error("image walk counter beyond merged grid");

	a_base_order: assert property (@(posedge clk) disable iff (!arst_n)
		(maxp1_q <= base_q) && ({1'b0, base_q} <= BASE_LIMIT))
		else $error("base below largest position or past limit");

	a_text_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && tok_s1.mode == MODE_TEXT && res.status == ST_OK)
			|=> base_q == $past(base_q) + 32'd1)
		else $error("text word did not advance base by one");
`endif

endmodule

`default_nettype wire

>>> sim/multimodal_rope_position_generator_top_tb.sv
// ----------------------------------------------------------------------------
// multimodal_rope_position_generator_top_tb
// Self-checking bench for the three-axis rotary position generator. Drives
// text, image, end-of-prompt and generated tokens with random gaps and random
// result back-pressure. An in-order predictor checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multimodal_rope_position_generator_top_tb;

	import mmrope_pkg::*;

	localparam int     MERGE        = 2;
	localparam int     GRID_LIMIT   = 1024;
	localparam longint POS_LIMIT    = 64'd2147483647;
	localparam int     RANDOM_ITEMS = 1600;
	localparam int     CYCLE_LIMIT  = 1000000;

	logic clk;
	logic arst_n;
	logic tok_valid;
	logic tok_ready;
	tok_t tok;
	logic pos_valid;
	logic pos_ready;
	pos_t pos;

	int words_sent;
	int cycle_cnt;
	int tx_burst;
	int rx_burst;

	class rope_pos_checker;
		logic [32:0]        base_pos;
		logic signed [32:0] max_pos;
		logic [31:0]        seen;
		logic signed [32:0] rope_ofs;
		bit                 in_run;
		logic [9:0]         row_idx;
		logic [9:0]         col_idx;
		logic [9:0]         run_rows;
		logic [9:0]         run_cols;
		pos_t               expected_pos_q[$];
		int                 errors;
		int                 checked;
		int                 mode_cnt[4];
		int                 status_cnt[4];

		function new();
			base_pos = '0;
			max_pos  = '1;
			seen     = '0;
			rope_ofs = '0;
			in_run   = 1'b0;
			row_idx  = '0;
			col_idx  = '0;
			run_rows = '0;
			run_cols = '0;
			errors   = 0;
			checked  = 0;
			foreach (mode_cnt[i]) mode_cnt[i] = 0;
			foreach (status_cnt[i]) status_cnt[i] = 0;
		endfunction

		// any error drops an open run and carries only the status
		function pos_t abort_run(logic [1:0] st);
			pos_t r;
			r = '0;
			r.status = st;
			in_run = 1'b0;
			return r;
		endfunction

		function bit side_ok(logic [10:0] s);
			return s != 0 && s <= GRID_LIMIT && (s % MERGE) == 0;
		endfunction

		function pos_t next_position(tok_t w);
			pos_t   r;
			longint b, mx, s, o, p, d, mr, mc, side, last;
			r  = '0;
			b  = base_pos;
			mx = max_pos;
			s  = seen;
			o  = rope_ofs;
			case (w.mode)
				MODE_TEXT: begin
					if (in_run)
						return abort_run(ST_MISMATCH);
					if (b > POS_LIMIT || seen == '1)
						return abort_run(ST_OVERFLOW);
					if (b > mx)
						max_pos = 33'(b);
					base_pos = 33'(b + 1);
					seen++;
					r.pos_time = b[30:0];
					r.pos_row  = b[30:0];
					r.pos_col  = b[30:0];
				end
				MODE_IMAGE: begin
					if (w.run_first) begin
						if (in_run)
							return abort_run(ST_MISMATCH);
						if (!side_ok(w.grid_rows) || !side_ok(w.grid_cols))
							return abort_run(ST_GRID);
						mr = w.grid_rows / MERGE;
						mc = w.grid_cols / MERGE;
						side = (mr > mc) ? mr : mc;
						if (b + side - 1 > POS_LIMIT)
							return abort_run(ST_OVERFLOW);
						run_rows = 10'(mr);
						run_cols = 10'(mc);
						row_idx  = '0;
						col_idx  = '0;
						in_run   = 1'b1;
					end else if (!in_run) begin
						return abort_run(ST_MISMATCH);
					end
					if (seen == '1)
						return abort_run(ST_OVERFLOW);
					seen++;
					p = b + row_idx;
					d = b + col_idx;
					r.pos_time = b[30:0];
					r.pos_row  = p[30:0];
					r.pos_col  = d[30:0];
					col_idx++;
					if (col_idx >= run_cols) begin
						col_idx = '0;
						row_idx++;
						if (row_idx >= run_rows) begin
							side = (run_rows > run_cols) ? run_rows : run_cols;
							last = b + side - 1;
							if (last > mx)
								max_pos = 33'(last);
							base_pos = 33'(b + side);
							row_idx  = '0;
							in_run   = 1'b0;
						end
					end
				end
				MODE_END: begin
					if (in_run)
						return abort_run(ST_MISMATCH);
					d = (s == 0) ? 0 : mx + 1 - s;
					if (d > POS_LIMIT || d < -POS_LIMIT - 1)
						return abort_run(ST_OVERFLOW);
					rope_ofs    = 33'(d);
					r.delta_out = d[31:0];
				end
				default: begin
					if (in_run)
						return abort_run(ST_MISMATCH);
					if (seen == '1)
						return abort_run(ST_OVERFLOW);
					p = s + o;
					if (p < 0 || p > POS_LIMIT)
						return abort_run(ST_OVERFLOW);
					seen++;
					r.pos_time = p[30:0];
					r.pos_row  = p[30:0];
					r.pos_col  = p[30:0];
				end
			endcase
			return r;
		endfunction

		function void note_token(tok_t w);
			pos_t want;
			want = next_position(w);
			mode_cnt[w.mode]++;
			expected_pos_q = {expected_pos_q, want};
		endfunction

		function void check_position(pos_t got);
			pos_t want;
			checked++;
			status_cnt[got.status]++;
			if (expected_pos_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: stray result t=%0d h=%0d w=%0d d=%0d st=%0d",
						$realtime, got.pos_time, got.pos_row, got.pos_col, got.delta_out,
						got.status);
				return;
			end
			want = expected_pos_q.pop_front();
			if (got.pos_time !== want.pos_time || got.pos_row !== want.pos_row ||
					got.pos_col !== want.pos_col || got.delta_out !== want.delta_out ||
					got.status !== want.status) begin
				errors++;
				if (errors <= 10) begin
					$write("%0t: result %0d exp t=%0d h=%0d w=%0d d=%0d st=%0d",
						$realtime, checked, want.pos_time, want.pos_row, want.pos_col,
						want.delta_out, want.status);
					$display(", got t=%0d h=%0d w=%0d d=%0d st=%0d", got.pos_time,
						got.pos_row, got.pos_col, got.delta_out, got.status);
				end
			end
		endfunction

		function int pending();
			return expected_pos_q.size();
		endfunction

		function void close();
			if (expected_pos_q.size() != 0) begin
				errors += expected_pos_q.size();
				$display("%0d expected result words never arrived", expected_pos_q.size());
			end
		endfunction
	endclass

	rope_pos_checker sb = new();

	multimodal_rope_position_generator_top #(
		.MERGE_SIZE(MERGE),
		.GRID_MAX  (GRID_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_valid(tok_valid),
		.tok_ready(tok_ready),
		.tok      (tok),
		.pos_valid(pos_valid),
		.pos_ready(pos_ready),
		.pos      (pos)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (tok_valid && tok_ready)
			sb.note_token(tok);
		if (pos_valid && pos_ready)
			sb.check_position(pos);
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("multimodal_rope_position_generator_top regression: fail");
			$finish;
		end
	end

	// random wait per word, with occasional stretches of back-to-back words
	function automatic int draw_wait(inout int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	// fields are cut to their widths here
	function automatic tok_t token_word(int mode, int first, int rows, int cols);
		tok_t w;
		w.mode      = 2'(mode);
		w.run_first = 1'(first);
		w.grid_rows = 11'(rows);
		w.grid_cols = 11'(cols);
		return w;
	endfunction

	task automatic send_word(input tok_t w);
		int gap;
		gap = draw_wait(tx_burst);
		if (gap > 0) begin
			tok_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok       <= w;
		tok_valid <= 1'b1;
		do @(posedge clk); while (!tok_ready);
		words_sent++;
	endtask

	// first word carries the grid; continuation words carry junk grid bits
	task automatic send_image_run(input int rows, input int cols, input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if (k == 0)
				send_word(token_word(MODE_IMAGE, 1'b1, rows, cols));
			else
				send_word(token_word(MODE_IMAGE, 1'b0, $urandom, $urandom));
		end
	endtask

	task automatic wait_idle();
		tok_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic receive_loop();
		int stall;
		forever begin
			stall = draw_wait(rx_burst);
			if (stall > 0) begin
				pos_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pos_ready <= 1'b1;
			do @(posedge clk); while (!pos_valid);
		end
	endtask

	initial begin
		int pick, rows, cols, total, cut, run_no;
		arst_n     = 1'b0;
		tok_valid  = 1'b0;
		tok        = '0;
		pos_ready  = 1'b0;
		words_sent = 0;
		cycle_cnt  = 0;
		tx_burst   = 0;
		rx_burst   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			receive_loop();
		join_none

		// empty prompt, then junk grid bits on text
		send_word(token_word(MODE_END, 1'b0, 11'd0, 11'd0));
		send_word(token_word(MODE_GEN, 1'b0, 11'd0, 11'd0));
		send_word(token_word(MODE_TEXT, 1'b0, 11'd2047, 11'd2047));
		send_word(token_word(MODE_TEXT, 1'b1, 11'd0, 11'd0));
		// continuation with no open run, then the bad grid shapes
		send_word(token_word(MODE_IMAGE, 1'b0, 11'd4, 11'd4));
		send_word(token_word(MODE_IMAGE, 1'b1, 11'd0, 11'd4));
		send_word(token_word(MODE_IMAGE, 1'b1, 11'd4, 11'd3));
		send_word(token_word(MODE_IMAGE, 1'b1, 11'd1026, 11'd2));
		send_word(token_word(MODE_IMAGE, 1'b1, 11'd2047, 11'd2047));
		// restart inside a run kills both, so the next continuation fails too
		send_image_run(4, 4, 2);
		send_word(token_word(MODE_IMAGE, 1'b1, 11'd4, 11'd4));
		send_word(token_word(MODE_IMAGE, 1'b0, 11'd0, 11'd0));
		send_image_run(4, 2, 2);
		send_image_run(2, 2, 1);
		send_image_run(2, 4, 1);
		send_word(token_word(MODE_TEXT, 1'b0, 11'd0, 11'd0));
		send_image_run(4, 4, 1);
		send_word(token_word(MODE_END, 1'b0, 11'd0, 11'd0));
		send_image_run(4, 4, 3);
		send_word(token_word(MODE_GEN, 1'b0, 11'd0, 11'd0));
		// prompt goes on after an end word
		send_word(token_word(MODE_END, 1'b0, 11'd0, 11'd0));
		send_word(token_word(MODE_TEXT, 1'b0, 11'd0, 11'd0));
		send_word(token_word(MODE_GEN, 1'b0, 11'd0, 11'd0));

		wait_idle();

		words_sent = 0;
		run_no     = 0;
		while (words_sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_word(token_word(MODE_TEXT, $urandom, $urandom, $urandom));
			end else if (pick < 65) begin
				run_no++;
				if (run_no == 3) begin
					rows = GRID_LIMIT;
					cols = MERGE;
				end else if (run_no == 9) begin
					rows = MERGE;
					cols = GRID_LIMIT;
				end else begin
					rows = MERGE * $urandom_range(1, 6);
					cols = MERGE * $urandom_range(1, 6);
				end
				total = (rows / MERGE) * (cols / MERGE);
				send_image_run(rows, cols, total);
			end else if (pick < 70) begin
				send_word(token_word(MODE_END, $urandom, $urandom, $urandom));
			end else if (pick < 82) begin
				send_word(token_word(MODE_GEN, $urandom, $urandom, $urandom));
			end else if (pick < 90) begin
				// run cut short by some other word
				rows  = MERGE * $urandom_range(1, 6);
				cols  = MERGE * $urandom_range(2, 6);
				total = (rows / MERGE) * (cols / MERGE);
				cut   = $urandom_range(1, total - 1);
				send_image_run(rows, cols, cut);
				send_word(token_word($urandom_range(0, 3), 1'b1, $urandom, $urandom));
			end else begin
				send_word(token_word($urandom, $urandom, $urandom, $urandom));
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		sb.close();
		$display("covered %0d words: text %0d, image %0d, end %0d, generated %0d",
			sb.mode_cnt[0] + sb.mode_cnt[1] + sb.mode_cnt[2] + sb.mode_cnt[3],
			sb.mode_cnt[MODE_TEXT], sb.mode_cnt[MODE_IMAGE], sb.mode_cnt[MODE_END],
			sb.mode_cnt[MODE_GEN]);
		$display("results %0d: ok %0d, bad grid %0d, run mismatch %0d, overflow %0d; errors %0d",
			sb.checked, sb.status_cnt[ST_OK], sb.status_cnt[ST_GRID],
			sb.status_cnt[ST_MISMATCH], sb.status_cnt[ST_OVERFLOW], sb.errors);
		if (sb.errors == 0)
			$display("multimodal_rope_position_generator_top regression: pass");
		else
			$display("multimodal_rope_position_generator_top regression: fail");
		$finish;
	end

endmodule
